@@ hw/rtl/gabc_pkg.sv @@
// shared types and constants for the gamepad axis and button conditioner
`timescale 1ns / 1ps
package gabc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    CFG_PAN_DZ     = 3'd0,
    CFG_PAN_EXPO   = 3'd1,
    CFG_TILT_DZ    = 3'd2,
    CFG_TILT_EXPO  = 3'd3,
    CFG_SAVE_HOLD  = 3'd4,
    CFG_RECALL_MAX = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_BLEND,
    ST_DONE
  } lane_state_t;

  // control from the top to each lane
  typedef struct packed {
    logic        start;
    logic [15:0] deadzone;
    logic [15:0] expo;
  } lane_ctrl_t;

  // status from each lane
  typedef struct packed {
    logic        done;
    logic [14:0] mag;
  } lane_stat_t;

endpackage

@@ hw/rtl/gabc_axis_lane.sv @@
// one stick axis: deadzone, restoring divide and expo curve
`timescale 1ns / 1ps
module gabc_axis_lane #(
  parameter int unsigned AXIS_FULL_SCALE = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gabc_pkg::lane_ctrl_t ctrl,
  input  logic [15:0]         raw,
  output gabc_pkg::lane_stat_t stat
);

  localparam int unsigned FsW = $clog2(AXIS_FULL_SCALE + 1);
  localparam int unsigned NumW = FsW + 32;
  localparam int unsigned DenW = FsW + 17;
  localparam logic [FsW-1:0] Fs = FsW'(AXIS_FULL_SCALE);

  gabc_pkg::lane_state_t state_r, state_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [NumW-1:0] rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [16:0]     q_r, q_nxt;
  logic [33:0]     sq_r, sq_nxt;
  logic [16:0]     cube_r, cube_nxt;
  logic [14:0]     mag_r, mag_nxt;
  logic [15:0]     expo_r, expo_nxt;

  logic [15:0]     a_abs;
  logic [FsW-1:0]  a_cl;
  logic [FsW+16:0] num0, thr0;
  logic [NumW+1:0] trial;
  logic [16:0]     m_cl;
  logic [50:0]     cube_full;
  logic [33:0]     y;
  logic [17:0]     r;

  always_comb begin
    a_abs = raw[15] ? 16'(-raw) : raw;
    a_cl  = ({16'd0, a_abs} > {{(16-FsW+1){1'b0}}, Fs}) ? Fs : FsW'(a_abs);
    num0  = {a_cl, 16'd0} + (FsW+17)'(0);
    thr0  = (FsW+17)'(ctrl.deadzone) * (FsW+17)'(Fs);
    trial = {2'b00, rem_r} - ({{(NumW+2-DenW){1'b0}}, den_r} << cnt_r[4:0]);
    m_cl  = (q_r > 17'd65536) ? 17'd65536 : q_r;
    cube_full = sq_r * m_cl;
    y = 34'(q_r) * 34'(17'd65536 - {1'b0, expo_r}) + 34'(cube_r) * 34'(expo_r);
    r = 18'((y + 34'h10000) >> 17);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    sq_nxt = sq_r;
    cube_nxt = cube_r;
    mag_nxt = mag_r;
    expo_nxt = expo_r;
    case (state_r)
      gabc_pkg::ST_IDLE: begin
        if (ctrl.start) begin
          state_nxt = gabc_pkg::ST_START;
        end
      end
      gabc_pkg::ST_START: begin
        expo_nxt = ctrl.expo;
        den_nxt = DenW'(Fs) * DenW'(17'd65536 - {1'b0, ctrl.deadzone});
        q_nxt = '0;
        cnt_nxt = 6'd17;
        if (num0 < thr0) begin
          mag_nxt = '0;
          state_nxt = gabc_pkg::ST_DONE;
        end else begin
          rem_nxt = NumW'(num0 - thr0) << 16;
          state_nxt = gabc_pkg::ST_DIV;
        end
      end
      gabc_pkg::ST_DIV: begin
        if (cnt_r == 6'd17) begin
          // quotient beyond 17 bits saturates straight away
          if (!trial[NumW+1]) begin
            q_nxt = 17'h1ffff;
            state_nxt = gabc_pkg::ST_SQ;
          end
          cnt_nxt = 6'd16;
        end else begin
          // one quotient bit a cycle
          if (!trial[NumW+1]) begin
            rem_nxt = trial[NumW-1:0];
            q_nxt = {q_r[15:0], 1'b1};
          end else begin
            q_nxt = {q_r[15:0], 1'b0};
          end
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_nxt = gabc_pkg::ST_SQ;
          end
        end
      end
      gabc_pkg::ST_SQ: begin
        q_nxt = m_cl;
        sq_nxt = m_cl * m_cl;
        state_nxt = gabc_pkg::ST_CUBE;
      end
      gabc_pkg::ST_CUBE: begin
        cube_nxt = 17'((cube_full + 51'h80000000) >> 32);
        state_nxt = gabc_pkg::ST_BLEND;
      end
      gabc_pkg::ST_BLEND: begin
        mag_nxt = (r > 18'd32767) ? 15'h7fff : r[14:0];
        state_nxt = gabc_pkg::ST_DONE;
      end
      gabc_pkg::ST_DONE: begin
        state_nxt = gabc_pkg::ST_IDLE;
      end
      default: state_nxt = gabc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gabc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    sq_r <= sq_nxt;
    cube_r <= cube_nxt;
    mag_r <= mag_nxt;
    expo_r <= expo_nxt;
  end

  assign stat.done = (state_r == gabc_pkg::ST_DONE);
  assign stat.mag = mag_r;

endmodule

@@ hw/rtl/gamepad_axis_button_conditioner.sv @@
// top level of the gamepad axis and button conditioner
`timescale 1ns / 1ps
// usage
//   in_* carries one controller snapshot a request; out_* carries one result
//   per snapshot. cfg_* writes the six tuning registers while the block idles.
// operation
//   two axis lanes run side by side on pan and tilt, each with its own
//   restoring divider (one quotient bit a cycle) and multipliers; the merge
//   stage applies signs, zoom difference and the button events.
// sequence
//   from acceptance to out_tvalid: start, done and merge when both axes sit in
//   the deadzone; otherwise start, a divide (range check, then 17 quotient bits,
//   cut short when the range check saturates), square, cube, blend, done and
//   merge. one snapshot in flight; the next is taken the cycle after the merge.
// reset
//   rst_n low clears the button history, drops any request in flight and
//   restores register defaults.
// stall
//   a held result waits in the output register; meanwhile one more snapshot may
//   be taken and computed, then waits in snap_r and mag regs with in_tready low.
module gamepad_axis_button_conditioner #(
  parameter int unsigned AXIS_FULL_SCALE    = 512,
  parameter int unsigned TRIGGER_FULL_SCALE = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // connected, axis_pan, axis_tilt, trigger_in, trigger_out, save_btn,
  // recall_btn, enc_btn, thumb_left, thumb_right, now_ms, zero pad
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // stamp_ms, pan_velocity, tilt_velocity, zoom_velocity, preset_save,
  // preset_recall, reset_encoders, diagnostics_dump, zero pad
  output logic [87:0] out_tdata,
  input  logic        cfg_we,
  input  logic [gabc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [10:0] TrigFs =
    (TRIGGER_FULL_SCALE > 1023) ? 11'd1023 : 11'(TRIGGER_FULL_SCALE);

  logic [15:0] pan_dz_r, pan_ex_r, tilt_dz_r, tilt_ex_r, hold_r, recall_r;
  logic busy_r, out_v_r;
  logic [89:0] snap_r;
  logic [87:0] out_r;
  logic save_active_r, prev_b_r, prev_st_r, prev_tl_r, prev_tr_r;
  logic [31:0] save_start_r, b_time_r;

  gabc_pkg::lane_ctrl_t pan_ctrl, tilt_ctrl;
  gabc_pkg::lane_stat_t pan_stat, tilt_stat;
  logic pan_done_r, tilt_done_r;
  logic [14:0] pan_mag_r, tilt_mag_r;

  logic accept;
  assign in_tready = !busy_r;
  assign accept = in_tvalid && in_tready;

  assign pan_ctrl = '{start: accept, deadzone: pan_dz_r, expo: pan_ex_r};
  assign tilt_ctrl = '{start: accept, deadzone: tilt_dz_r, expo: tilt_ex_r};

  // lanes read the captured snapshot, starting the cycle after acceptance
  gabc_axis_lane #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_pan (
    .clk(clk), .rst_n(rst_n), .ctrl(pan_ctrl), .raw(snap_r[16:1]),
    .stat(pan_stat));
  gabc_axis_lane #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_tilt (
    .clk(clk), .rst_n(rst_n), .ctrl(tilt_ctrl), .raw(snap_r[32:17]),
    .stat(tilt_stat));

  // snapshot fields
  logic conn, ba, bb, bs, tl, tr;
  logic [31:0] now;
  logic [10:0] tin, tout;
  assign conn = snap_r[0];
  assign tin  = ({1'b0, snap_r[42:33]} > TrigFs) ? TrigFs : {1'b0, snap_r[42:33]};
  assign tout = ({1'b0, snap_r[52:43]} > TrigFs) ? TrigFs : {1'b0, snap_r[52:43]};
  assign ba = snap_r[53];
  assign bb = snap_r[54];
  assign bs = snap_r[55];
  assign tl = snap_r[56];
  assign tr = snap_r[57];
  assign now = snap_r[89:58];

  // merge once both lanes are done and the result register is free
  logic merge;
  assign merge = busy_r && pan_done_r && tilt_done_r && (!out_v_r || out_tready);

  logic save, recall, rst_pulse, diag;
  logic [15:0] pan_v, tilt_v;
  logic [10:0] zoom;
  always_comb begin
    save = !ba && save_active_r && ((now - save_start_r) >= {16'd0, hold_r});
    recall = prev_b_r && !bb && ((now - b_time_r) <= {16'd0, recall_r});
    rst_pulse = !prev_st_r && bs;
    diag = tl && tr && !(prev_tl_r && prev_tr_r);
    pan_v = snap_r[16] ? -{1'b0, pan_mag_r} : {1'b0, pan_mag_r};
    // tilt negated
    tilt_v = snap_r[32] ? {1'b0, tilt_mag_r} : -{1'b0, tilt_mag_r};
    zoom = tin - tout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_dz_r <= 16'd5243;
      pan_ex_r <= 16'd19661;
      tilt_dz_r <= 16'd5243;
      tilt_ex_r <= 16'd19661;
      hold_r <= 16'd2000;
      recall_r <= 16'd1500;
      busy_r <= 1'b0;
      out_v_r <= 1'b0;
      pan_done_r <= 1'b0;
      tilt_done_r <= 1'b0;
      save_active_r <= 1'b0;
      save_start_r <= '0;
      b_time_r <= '0;
      prev_b_r <= 1'b0;
      prev_st_r <= 1'b0;
      prev_tl_r <= 1'b0;
      prev_tr_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gabc_pkg::CFG_PAN_DZ:     pan_dz_r <= cfg_wdata;
          gabc_pkg::CFG_PAN_EXPO:   pan_ex_r <= cfg_wdata;
          gabc_pkg::CFG_TILT_DZ:    tilt_dz_r <= cfg_wdata;
          gabc_pkg::CFG_TILT_EXPO:  tilt_ex_r <= cfg_wdata;
          gabc_pkg::CFG_SAVE_HOLD:  hold_r <= cfg_wdata;
          gabc_pkg::CFG_RECALL_MAX: recall_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (accept) begin
        busy_r <= 1'b1;
        pan_done_r <= 1'b0;
        tilt_done_r <= 1'b0;
      end
      if (pan_stat.done) pan_done_r <= 1'b1;
      if (tilt_stat.done) tilt_done_r <= 1'b1;
      if (merge) begin
        busy_r <= 1'b0;
        out_v_r <= 1'b1;
        if (!conn) begin
          prev_b_r <= 1'b0;
          prev_st_r <= 1'b0;
          prev_tl_r <= 1'b0;
          prev_tr_r <= 1'b0;
          save_active_r <= 1'b0;
          b_time_r <= '0;
        end else begin
          if (ba) begin
            if (!save_active_r) begin
              save_active_r <= 1'b1;
              save_start_r <= now;
            end
          end else begin
            save_active_r <= 1'b0;
          end
          if (!prev_b_r && bb) b_time_r <= now;
          prev_b_r <= bb;
          prev_st_r <= bs;
          prev_tl_r <= tl;
          prev_tr_r <= tr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) snap_r <= in_tdata[89:0];
    if (pan_stat.done) pan_mag_r <= pan_stat.mag;
    if (tilt_stat.done) tilt_mag_r <= tilt_stat.mag;
    if (merge) begin
      if (conn) begin
        out_r <= {9'd0, diag, rst_pulse, recall, save, zoom, tilt_v, pan_v, now};
      end else begin
        out_r <= {56'd0, now};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

endmodule
